/* design/assert_macros.svh */
// Assertion macros shared by the checker files of the motion profile block.
// Stand-alone header; takes nothing from other files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held (active-low reset).
`define SOFMP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SOFMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/sofmp_pkg.sv */
// Package of the S-curve motion profile block: stream widths, register codes,
// sequencer states and fixed-point constants. No dependencies.
package sofmp_pkg;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 144;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Operand width of the shared multiplier
    localparam int MUL_W = 32;

    // Width of the filter2_len register
    localparam int FILTER2_W = 9;

    // 1.0 in Q16.16, at the width of the impulse budget
    localparam logic [39:0] ONE_Q16 = 40'h00_0001_0000;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_FILTER1_LEN       = 3'd0,
        REG_FILTER2_LEN       = 3'd1,
        REG_IMPULSE_TICKS     = 3'd2,
        REG_START_LEVEL       = 3'd3,
        REG_VELOCITY_SCALE    = 3'd4,
        REG_INITIAL_VELOCITY  = 3'd5,
        REG_STEP_TIME         = 3'd6,
        REG_INVERSE_STEP_TIME = 3'd7
    } cfg_reg_t;

    // Tick sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_SUM,
        ST_REFILL,
        ST_MUL_VLO,
        ST_MUL_VHI,
        ST_VEL,
        ST_MUL_POS,
        ST_MUL_ACC,
        ST_ACC,
        ST_MUL_JRK,
        ST_OUT
    } state_t;

endpackage

/* design/sofmp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; contents are undefined until written.
module sofmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and read-first registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/sofmp_mul.sv */
// Shared unsigned multiplier with a registered product, loaded on enable.
// Depends on sofmp_pkg for the operand width.
module sofmp_mul (
    input  logic                             clk,
    input  logic                             en,
    input  logic [sofmp_pkg::MUL_W-1:0]      a,
    input  logic [sofmp_pkg::MUL_W-1:0]      b,
    output logic [2*sofmp_pkg::MUL_W-1:0]    prod
);
    import sofmp_pkg::*;

    logic [2*MUL_W-1:0] prod_reg;

    // One product per issue; held until the next issue
    always_ff @(posedge clk) begin
        if (en) begin
            prod_reg <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
        end
    end

    assign prod = prod_reg;

endmodule

/* design/second_order_filter_motion_profile.sv */
// Top level of the two-stage box-filter (S-curve) motion profile generator.
// Depends on sofmp_pkg, sofmp_ram (level history) and sofmp_mul.
//
// Each beat on the s_ channel is one time tick: s_tdata[0] restarts the
// profile from the configuration registers, s_tlast marks the final tick and
// comes back as m_tlast. Each tick gives one m_ beat with velocity,
// position, acceleration and jerk. Registers are to be written on the cfg_ port
// only while no tick is in flight; the block itself does not enforce this.
// The next tick is taken only after the result of the previous one has
// entered the output register. The shared 32x32 multiplier is used five
// times per tick in a dependent chain. When the window length is zero, or
// neither equals that of the previous tick nor is one more, the window sum
// is rebuilt from the history RAM, one read a cycle, before the first
// multiply of the tick.
// Reset clears the profile state to zero and the registers to their
// defaults; the history RAM is not cleared (only entries written since the
// last restart are read). A stalled receiver holds the result in the output
// register; one more tick is accepted and worked up to its result meanwhile.
module second_order_filter_motion_profile #(
    parameter int WINDOW_MAX = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Tick stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sofmp_pkg::S_TDATA_W-1:0]    s_tdata,  // [0] start_profile
    input  logic                               s_tlast,  // final_tick
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] velocity, [79:32] position, [111:80] acceleration, [143:112] jerk
    output logic [sofmp_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,  // last_segment
    // Configuration writes
    input  logic                               cfg_wr_en,
    input  logic [sofmp_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [sofmp_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import sofmp_pkg::*;

    localparam int AW   = $clog2(WINDOW_MAX);
    localparam int CW   = $clog2(WINDOW_MAX + 1);
    localparam int CMPW = (CW > FILTER2_W) ? CW : FILTER2_W;
    localparam int SUMW = 32 + AW;
    localparam int VPW  = 65 + AW;

    // Magnitude of a 33-bit signed value known to stay below 2^32
    function automatic logic [31:0] mag32(input logic [32:0] v);
        logic [32:0] m;
        m = v[32] ? -v : v;
        return m[31:0];
    endfunction

    // Round product half up (16 or 17 bit shift), then apply the sign
    function automatic logic [49:0] round_signed(input logic [63:0] p,
                                                 input logic neg,
                                                 input logic sh17);
        logic [64:0] t;
        logic [48:0] m;
        t = {1'b0, p} + (sh17 ? 65'h1_0000 : 65'h8000);
        m = sh17 ? {1'b0, t[64:17]} : t[64:16];
        return neg ? -{1'b0, m} : {1'b0, m};
    endfunction

    function automatic logic [31:0] sat32(input logic [49:0] v);
        logic [31:0] r;
        if (v[49:31] == {19{v[49]}}) begin
            r = v[31:0];
        end else begin
            r = v[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [47:0] sat48(input logic [49:0] v);
        logic [47:0] r;
        if (v[49:47] == {3{v[49]}}) begin
            r = v[47:0];
        end else begin
            r = v[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        end
        return r;
    endfunction

    // Configuration registers
    logic [15:0]          f1_len_reg;
    logic [FILTER2_W-1:0] f2_len_reg;
    logic [39:0]          imp_cfg_reg;
    logic [31:0]          start_level_reg;
    logic [31:0]          vscale_reg;
    logic [31:0]          init_vel_reg;
    logic [31:0]          step_reg;
    logic [31:0]          inv_step_reg;

    // Profile state
    state_t               state_reg, state_next;
    logic [39:0]          impulse_reg;
    logic [31:0]          level_reg;
    logic [SUMW-1:0]      sum_reg;
    logic [AW-1:0]        slot_reg;
    logic [CW-1:0]        filled_reg;
    logic [CW-1:0]        span_reg;
    logic [CW-1:0]        span_old_reg;
    logic [31:0]          pv_reg;
    logic [47:0]          pp_reg;
    logic [31:0]          pa_reg;
    logic [CW-1:0]        k_reg;
    logic                 pend_reg;
    logic                 m_tvalid_reg;

    // Working values
    logic [AW-1:0]        rptr_reg;
    logic [63:0]          lo_prod_reg;
    logic [31:0]          vel_reg;
    logic [47:0]          pos_reg;
    logic [31:0]          acc_reg;
    logic                 neg_reg;
    logic                 last_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    // Handshake and control
    logic                 s_tready_int;
    logic                 accept;
    logic                 out_free;
    logic                 mul_en;
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [31:0]          ram_rdata;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic                 mul_neg;
    logic [63:0]          prod;

    assign accept   = s_tvalid && s_tready_int;
    assign out_free = !m_tvalid_reg || m_tready;

    // Impulse draw and clamped level
    logic               imp_ge;
    logic [39:0]        imp_new;
    logic signed [33:0] draw;
    logic signed [33:0] lvl_sum;
    logic signed [33:0] lvl_lim;
    logic [31:0]        lvl_new;

    always_comb begin
        imp_ge  = (impulse_reg >= ONE_Q16);
        imp_new = imp_ge ? impulse_reg - ONE_Q16 : '0;
        draw    = imp_ge ? $signed(ONE_Q16[33:0])
                         : $signed({18'd0, impulse_reg[15:0]}) - $signed(ONE_Q16[33:0]);
        lvl_sum = $signed({2'b00, level_reg}) + draw;
        lvl_lim = $signed({2'b00, f1_len_reg, 16'h0000});
        if (lvl_sum < 0) begin
            lvl_new = '0;
        end else if (lvl_sum > lvl_lim) begin
            lvl_new = lvl_lim[31:0];
        end else begin
            lvl_new = lvl_sum[31:0];
        end
    end

    // Fill count, window span and address of the level leaving the window
    logic [CW-1:0]   filled_new;
    logic [CMPW-1:0] f2_ext;
    logic [CMPW-1:0] f2_cap;
    logic [CW-1:0]   span_new;
    logic [CW:0]     slide_w;
    logic [AW-1:0]   slide_addr;

    always_comb begin
        filled_new = (filled_reg == CW'(WINDOW_MAX)) ? filled_reg : filled_reg + CW'(1);
        f2_ext     = CMPW'(f2_len_reg);
        f2_cap     = (f2_ext > CMPW'(WINDOW_MAX)) ? CMPW'(WINDOW_MAX) : f2_ext;
        span_new   = (CW'(f2_cap) > filled_new) ? filled_new : CW'(f2_cap);
        if ((CW + 1)'(slot_reg) >= (CW + 1)'(span_new)) begin
            slide_w = (CW + 1)'(slot_reg) - (CW + 1)'(span_new);
        end else begin
            slide_w = (CW + 1)'(slot_reg) + (CW + 1)'(WINDOW_MAX) - (CW + 1)'(span_new);
        end
        slide_addr = slide_w[AW-1:0];
    end

    // Window update mode: grow by one, slide by one, or rebuild
    logic grow;
    logic slide;
    logic rebuild;

    always_comb begin
        grow    = ({1'b0, span_reg} == ({1'b0, span_old_reg} + (CW + 1)'(1)));
        slide   = (span_reg == span_old_reg) && (span_reg != '0);
        rebuild = !grow && !slide;
    end

    logic [AW-1:0] slot_inc;
    logic [AW-1:0] slot_dec;
    logic [AW-1:0] rptr_dec;

    assign slot_inc = (slot_reg == AW'(WINDOW_MAX - 1)) ? '0 : slot_reg + AW'(1);
    assign slot_dec = (slot_reg == '0) ? AW'(WINDOW_MAX - 1) : slot_reg - AW'(1);
    assign rptr_dec = (rptr_reg == '0) ? AW'(WINDOW_MAX - 1) : rptr_reg - AW'(1);

    // Velocity from the two partial products, rounded and saturated
    logic [VPW-1:0] vel_full;
    logic [31:0]    vel_val;

    always_comb begin
        vel_full = VPW'(lo_prod_reg) + VPW'({prod[AW+31:0], 32'd0}) + VPW'(32'h8000);
        vel_val  = (|vel_full[VPW-1:47]) ? 32'h7FFF_FFFF : {1'b0, vel_full[46:16]};
    end

    // Signed operands of the position, acceleration and jerk products
    logic [32:0] pos_opd;
    logic [32:0] acc_opd;
    logic [32:0] jrk_opd;

    assign pos_opd = {pv_reg[31], pv_reg} + {1'b0, vel_reg};
    assign acc_opd = {1'b0, vel_reg} - {pv_reg[31], pv_reg};
    assign jrk_opd = {acc_reg[31], acc_reg} - {pa_reg[31], pa_reg};

    // Shared multiplier operand selection
    always_comb begin
        mul_a   = sum_reg[31:0];
        mul_b   = vscale_reg;
        mul_neg = 1'b0;
        case (state_reg)
            ST_MUL_VHI: begin
                mul_a = 32'(sum_reg[SUMW-1:32]);
            end
            ST_MUL_POS: begin
                mul_a   = mag32(pos_opd);
                mul_b   = step_reg;
                mul_neg = pos_opd[32];
            end
            ST_MUL_ACC: begin
                mul_a   = mag32(acc_opd);
                mul_b   = inv_step_reg;
                mul_neg = acc_opd[32];
            end
            ST_MUL_JRK: begin
                mul_a   = mag32(jrk_opd);
                mul_b   = inv_step_reg;
                mul_neg = jrk_opd[32];
            end
            default: begin
            end
        endcase
    end

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_LEVEL;
            ST_LEVEL:   state_next = ST_SUM;
            ST_SUM:     state_next = rebuild ? ST_REFILL : ST_MUL_VLO;
            ST_REFILL:  if (k_reg >= span_reg) state_next = ST_MUL_VLO;
            ST_MUL_VLO: state_next = ST_MUL_VHI;
            ST_MUL_VHI: state_next = ST_VEL;
            ST_VEL:     state_next = ST_MUL_POS;
            ST_MUL_POS: state_next = ST_MUL_ACC;
            ST_MUL_ACC: state_next = ST_ACC;
            ST_ACC:     state_next = ST_MUL_JRK;
            ST_MUL_JRK: state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_tready_int = 1'b0;
        mul_en       = 1'b0;
        ram_we       = 1'b0;
        ram_raddr    = rptr_reg;
        unique case (state_reg)
            ST_IDLE:    s_tready_int = 1'b1;
            ST_LEVEL:   ram_raddr = slide_addr;
            ST_SUM:     ram_we = 1'b1;
            ST_MUL_VLO,
            ST_MUL_VHI,
            ST_MUL_POS,
            ST_MUL_ACC,
            ST_MUL_JRK: mul_en = 1'b1;
            default: begin
            end
        endcase
    end

    // Level history
    sofmp_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_MAX)
    ) u_hist (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (level_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared multiplier
    sofmp_mul u_mul (
        .clk  (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_len_reg      <= 16'd1;
            f2_len_reg      <= FILTER2_W'(1);
            imp_cfg_reg     <= '0;
            start_level_reg <= '0;
            vscale_reg      <= '0;
            init_vel_reg    <= '0;
            step_reg        <= 32'd655;
            inv_step_reg    <= 32'd6553600;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_FILTER1_LEN:       f1_len_reg      <= cfg_wr_data[15:0];
                REG_FILTER2_LEN:       f2_len_reg      <= cfg_wr_data[FILTER2_W-1:0];
                REG_IMPULSE_TICKS:     imp_cfg_reg     <= cfg_wr_data;
                REG_START_LEVEL:       start_level_reg <= cfg_wr_data[31:0];
                REG_VELOCITY_SCALE:    vscale_reg      <= cfg_wr_data[31:0];
                REG_INITIAL_VELOCITY:  init_vel_reg    <= cfg_wr_data[31:0];
                REG_STEP_TIME:         step_reg        <= cfg_wr_data[31:0];
                REG_INVERSE_STEP_TIME: inv_step_reg    <= cfg_wr_data[31:0];
            endcase
        end
    end

    // Profile state and sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            impulse_reg  <= '0;
            level_reg    <= '0;
            sum_reg      <= '0;
            slot_reg     <= '0;
            filled_reg   <= '0;
            span_reg     <= '0;
            span_old_reg <= '0;
            pv_reg       <= '0;
            pp_reg       <= '0;
            pa_reg       <= '0;
            k_reg        <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // restart: reload from the registers before the tick
            if (accept && s_tdata[0]) begin
                impulse_reg  <= imp_cfg_reg;
                level_reg    <= start_level_reg;
                sum_reg      <= '0;
                slot_reg     <= '0;
                filled_reg   <= '0;
                span_old_reg <= '0;
                pv_reg       <= init_vel_reg;
                pp_reg       <= '0;
                pa_reg       <= '0;
            end

            // draw, level and window span
            if (state_reg == ST_LEVEL) begin
                impulse_reg <= imp_new;
                level_reg   <= lvl_new;
                filled_reg  <= filled_new;
                span_reg    <= span_new;
            end

            // level stored; window sum updated or rebuild started
            if (state_reg == ST_SUM) begin
                if (grow) begin
                    sum_reg <= sum_reg + SUMW'(level_reg);
                end else if (slide) begin
                    sum_reg <= sum_reg + SUMW'(level_reg) - SUMW'(ram_rdata);
                end else begin
                    sum_reg <= (span_reg != '0) ? SUMW'(level_reg) : '0;
                end
                span_old_reg <= span_reg;
                slot_reg     <= slot_inc;
                k_reg        <= CW'(1);
                pend_reg     <= 1'b0;
            end

            // rebuild: one history read issued and one summed per cycle
            if (state_reg == ST_REFILL) begin
                if (pend_reg) begin
                    sum_reg <= sum_reg + SUMW'(ram_rdata);
                end
                if (k_reg < span_reg) begin
                    k_reg    <= k_reg + CW'(1);
                    pend_reg <= 1'b1;
                end else begin
                    pend_reg <= 1'b0;
                end
            end

            // result out, history of the outputs moves on
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
                pv_reg       <= vel_reg;
                pp_reg       <= pos_reg;
                pa_reg       <= acc_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working values and output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg <= s_tlast;
        end
        if (state_reg == ST_SUM) begin
            rptr_reg <= slot_dec;
        end
        if (state_reg == ST_REFILL && k_reg < span_reg) begin
            rptr_reg <= rptr_dec;
        end
        if (mul_en) begin
            neg_reg <= mul_neg;
        end
        if (state_reg == ST_MUL_VHI) begin
            lo_prod_reg <= prod;
        end
        if (state_reg == ST_VEL) begin
            vel_reg <= vel_val;
        end
        if (state_reg == ST_MUL_ACC) begin
            pos_reg <= sat48({{2{pp_reg[47]}}, pp_reg} + round_signed(prod, neg_reg, 1'b1));
        end
        if (state_reg == ST_ACC) begin
            acc_reg <= sat32(round_signed(prod, neg_reg, 1'b0));
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {sat32(round_signed(prod, neg_reg, 1'b0)),
                            acc_reg, pos_reg, vel_reg};
            m_tlast_reg <= last_reg;
        end
    end

    assign s_tready = s_tready_int;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* design/sofmp_checker.sv */
// Port-level checker of the motion profile block and its bind to the top level.
// Depends on sofmp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sofmp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sofmp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);

    // A stalled result beat holds
    `SOFMP_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")

    // One tick in work at a time
    `SOFMP_ASSERT(a_one_tick, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "tick taken while another is in work")

    // A new result only appears at the end of a tick's work
    `SOFMP_ASSERT(a_out_after_work, aclk, aresetn, $rose(m_tvalid) |-> $past(!s_tready), "result beat without a tick in work")

    // Velocity saturates at the top of its range and is never negative
    `SOFMP_ASSERT(a_vel_sign, aclk, aresetn, m_tvalid |-> !m_tdata[31], "negative velocity")

    // Reset empties the output register
    `SOFMP_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind second_order_filter_motion_profile sofmp_checker u_sofmp_checker (.*);

/* bench/tb_second_order_filter_motion_profile.sv */
// Testbench for the S-curve motion profile generator: random ticks and register
// settings, a bit-exact fixed-point predictor and a per-field result check.
// Depends on sofmp_pkg and the second_order_filter_motion_profile RTL.
module tb_second_order_filter_motion_profile;
    timeunit 1ns;
    timeprecision 1ps;

    import sofmp_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int HIST_DEPTH  = 256;
    localparam int RANDOM_TICKS = 600;
    localparam int CALM_FROM    = 500;    // no idling from this tick on

    typedef struct packed {
        logic start_profile;
        logic final_tick;
    } tick_t;

    typedef struct packed {
        logic [31:0] velocity;
        logic [47:0] position;
        logic [31:0] acceleration;
        logic [31:0] jerk;
        logic        last_segment;
    } profile_out_t;

    // DUT signals, all inputs known from time zero
    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_tvalid     = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata      = '0;   // [0] start_profile
    logic                   s_tlast      = 1'b0; // final_tick
    logic                   m_tvalid;
    logic                   m_tready     = 1'b0;
    // [31:0] velocity, [79:32] position, [111:80] acceleration, [143:112] jerk
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;             // last_segment
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data  = '0;

    // Stimulus and scoreboard
    tick_t        planned_ticks[$];
    profile_out_t predicted_results[$];
    tick_t        current_tick;
    int           ticks_planned  = 0;
    int           mismatch_count = 0;
    int           beat_no        = 0;
    int           gap_left       = 0;
    int           stall_left     = 0;
    bit           gaps_on        = 1'b0;

    // Register copy
    logic [15:0] f1_len;
    logic [8:0]  f2_len;
    logic [39:0] impulse_cfg;
    logic [31:0] start_lvl_cfg, vel_scale_cfg, init_vel_cfg, step_cfg, inv_step_cfg;

    // Profile state copy
    logic [31:0] lvl_hist [HIST_DEPTH];
    logic [31:0] level;
    logic [39:0] budget;
    longint      vel_prev, pos_prev, acc_prev;
    logic [7:0]  slot;
    int          filled;

    second_order_filter_motion_profile #(
        .WINDOW_MAX (HIST_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // (mag * b + half) >> sh, exact in wide arithmetic
    function automatic logic [63:0] round_mul_mag(input logic [63:0] mag, input logic [31:0] b,
                                                  input int sh);
        logic [127:0] p;
        p = {64'd0, mag} * {96'd0, b} + (128'd1 << (sh - 1));
        return 64'(p >> sh);
    endfunction

    // Signed product, rounded to nearest with ties away from zero
    function automatic longint signed_round_mul(input longint x, input logic [31:0] b,
                                                input int sh);
        logic [63:0] mag;
        logic [63:0] res;
        mag = (x < 0) ? 64'(-x) : 64'(x);
        res = round_mul_mag(mag, b, sh);
        return (x < 0) ? -longint'(res) : longint'(res);
    endfunction

    function automatic longint clamp_signed(input longint v, input int bits);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Advance the profile by one tick and give the result beat it should cause
    function automatic profile_out_t step_profile(input tick_t t);
        longint       draw, lvl, lim, vel, pos, acc, jrk;
        int           span;
        logic [7:0]   idx;
        logic [63:0]  sum, v;
        profile_out_t r;
        if (t.start_profile) begin
            level    = start_lvl_cfg;
            budget   = impulse_cfg;
            vel_prev = longint'(signed'(init_vel_cfg));
            pos_prev = 0;
            acc_prev = 0;
            slot     = '0;
            filled   = 0;
        end
        // impulse budget: +1.0 while it lasts, then the remainder less 1.0
        if (budget >= ONE_Q16) begin
            draw   = longint'(ONE_Q16);
            budget = budget - ONE_Q16;
        end else begin
            draw   = longint'(budget) - longint'(ONE_Q16);
            budget = '0;
        end
        lim = longint'(f1_len) <<< 16;
        lvl = longint'(level) + draw;
        if (lvl > lim) lvl = lim;
        if (lvl < 0) lvl = 0;
        level = 32'(lvl);
        lvl_hist[slot] = level;
        slot = slot + 8'd1;
        if (filled < HIST_DEPTH) filled++;
        // window over the newest levels, none from before the last restart
        span = int'(f2_len);
        if (span > HIST_DEPTH) span = HIST_DEPTH;
        if (span > filled) span = filled;
        sum = '0;
        for (int k = 1; k <= span; k++) begin
            idx = slot - 8'(k);
            sum = sum + 64'(lvl_hist[idx]);
        end
        v = round_mul_mag(sum, vel_scale_cfg, 16);
        if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
        vel = longint'(v);
        pos = clamp_signed(pos_prev + signed_round_mul(vel_prev + vel, step_cfg, 17), 48);
        acc = clamp_signed(signed_round_mul(vel - vel_prev, inv_step_cfg, 16), 32);
        jrk = clamp_signed(signed_round_mul(acc - acc_prev, inv_step_cfg, 16), 32);
        vel_prev = vel;
        pos_prev = pos;
        acc_prev = acc;
        r.velocity     = 32'(vel);
        r.position     = 48'(pos);
        r.acceleration = 32'(acc);
        r.jerk         = 32'(jrk);
        r.last_segment = t.final_tick;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    function automatic void plan_tick(input logic start, input logic fin);
        planned_ticks.push_back('{start_profile: start, final_tick: fin});
        ticks_planned++;
    endfunction

    // One register write, mirrored in the register copy
    task automatic write_reg(input cfg_reg_t idx, input logic [39:0] value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        case (idx)
            REG_FILTER1_LEN:       f1_len        = value[15:0];
            REG_FILTER2_LEN:       f2_len        = value[8:0];
            REG_IMPULSE_TICKS:     impulse_cfg   = value;
            REG_START_LEVEL:       start_lvl_cfg = value[31:0];
            REG_VELOCITY_SCALE:    vel_scale_cfg = value[31:0];
            REG_INITIAL_VELOCITY:  init_vel_cfg  = value[31:0];
            REG_STEP_TIME:         step_cfg      = value[31:0];
            REG_INVERSE_STEP_TIME: inv_step_cfg  = value[31:0];
            default: ;
        endcase
    endtask

    // Idle: every tick taken and every result beat back
    task automatic wait_idle();
        while (planned_ticks.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(posedge aclk);
    endtask

    // Tick driver: offers the next planned tick, with random gap bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) predicted_results.push_back(step_profile(current_tick));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (planned_ticks.size() != 0 && gaps_on
                             && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 8);
                    s_tvalid <= 1'b0;
                end else if (planned_ticks.size() != 0) begin
                    current_tick = planned_ticks.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(current_tick.start_profile);
                    s_tlast  <= current_tick.final_tick;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure, each beat checked field by field
    always @(posedge aclk) begin : result_monitor
        profile_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch($sformatf("beat %0d arrived with no tick outstanding",
                                              beat_no));
                end else begin
                    want = predicted_results.pop_front();
                    if (m_tdata[31:0] !== want.velocity)
                        report_mismatch($sformatf("beat %0d velocity %h, expected %h",
                                                  beat_no, m_tdata[31:0], want.velocity));
                    if (m_tdata[79:32] !== want.position)
                        report_mismatch($sformatf("beat %0d position %h, expected %h",
                                                  beat_no, m_tdata[79:32], want.position));
                    if (m_tdata[111:80] !== want.acceleration)
                        report_mismatch($sformatf("beat %0d acceleration %h, expected %h",
                                                  beat_no, m_tdata[111:80], want.acceleration));
                    if (m_tdata[143:112] !== want.jerk)
                        report_mismatch($sformatf("beat %0d jerk %h, expected %h",
                                                  beat_no, m_tdata[143:112], want.jerk));
                    if (m_tlast !== want.last_segment)
                        report_mismatch($sformatf("beat %0d last_segment %b, expected %b",
                                                  beat_no, m_tlast, want.last_segment));
                end
                beat_no++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #25_000_000;
        $display("tb_second_order_filter_motion_profile failed");
        $finish;
    end

    // Main sequence
    initial begin
        int          n;
        int          sel;
        int          shape;
        bit          first_rand;
        cfg_reg_t    idx;
        logic [39:0] val;
        logic [31:0] vel_tmp;

        // register defaults and cleared profile state after reset
        f1_len = 16'd1;  f2_len = 9'd1;  impulse_cfg = '0;  start_lvl_cfg = '0;
        vel_scale_cfg = '0;  init_vel_cfg = '0;  step_cfg = 32'd655;  inv_step_cfg = 32'd6553600;
        level = '0;  budget = '0;  vel_prev = 0;  pos_prev = 0;  acc_prev = 0;
        slot = '0;  filled = 0;
        first_rand = 1'b1;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        gaps_on = 1'b1;

        // ticks before any restart run from the reset state
        plan_tick(1'b0, 1'b0);
        plan_tick(1'b0, 1'b1);
        wait_idle();

        // short profile with a fractional budget and a negative start velocity
        write_reg(REG_FILTER1_LEN, 40'd3);
        write_reg(REG_FILTER2_LEN, 40'd4);
        write_reg(REG_IMPULSE_TICKS, 40'h05_8000);
        write_reg(REG_START_LEVEL, 40'd0);
        write_reg(REG_VELOCITY_SCALE, 40'h0100_0000);
        write_reg(REG_INITIAL_VELOCITY, 40'(32'hFFF0_0000));
        write_reg(REG_STEP_TIME, 40'd655);
        write_reg(REG_INVERSE_STEP_TIME, 40'd6553600);
        plan_tick(1'b1, 1'b0);
        repeat (8) plan_tick(1'b0, 1'b0);
        plan_tick(1'b0, 1'b1);
        wait_idle();

        // top values, initial velocity at minimum, window over history depth
        write_reg(REG_FILTER1_LEN, 40'hFFFF);
        write_reg(REG_FILTER2_LEN, 40'd511);
        write_reg(REG_IMPULSE_TICKS, 40'hFF_FFFF_FFFF);
        write_reg(REG_START_LEVEL, 40'hFFFF_FFFF);
        write_reg(REG_VELOCITY_SCALE, 40'hFFFF_FFFF);
        write_reg(REG_INITIAL_VELOCITY, 40'h8000_0000);
        write_reg(REG_STEP_TIME, 40'hFFFF_FFFF);
        write_reg(REG_INVERSE_STEP_TIME, 40'hFFFF_FFFF);
        plan_tick(1'b1, 1'b0);
        plan_tick(1'b0, 1'b0);
        plan_tick(1'b0, 1'b0);
        plan_tick(1'b0, 1'b1);
        wait_idle();

        // empty window, zero step and inverse, restart before the history fills
        write_reg(REG_FILTER2_LEN, 40'd0);
        write_reg(REG_STEP_TIME, 40'd0);
        write_reg(REG_INVERSE_STEP_TIME, 40'd0);
        write_reg(REG_INITIAL_VELOCITY, 40'h7FFF_FFFF);
        plan_tick(1'b1, 1'b0);
        plan_tick(1'b0, 1'b0);
        plan_tick(1'b1, 1'b0);
        wait_idle();

        // registers changed mid-profile, no restart
        write_reg(REG_FILTER2_LEN, 40'd2);
        write_reg(REG_VELOCITY_SCALE, 40'h0001_0000);
        write_reg(REG_STEP_TIME, 40'd655);
        write_reg(REG_INVERSE_STEP_TIME, 40'd6553600);
        plan_tick(1'b0, 1'b0);
        plan_tick(1'b0, 1'b0);
        plan_tick(1'b0, 1'b1);

        // random phases: mostly whole profiles, some continuations and noise
        ticks_planned = 0;
        while (ticks_planned < RANDOM_TICKS) begin
            wait_idle();
            gaps_on = (ticks_planned < CALM_FROM) && ($urandom_range(0, 3) != 0);
            if (first_rand || $urandom_range(0, 2) == 0) begin
                for (int i = 0; i < 8; i++) begin
                    if (!first_rand && $urandom_range(0, 1) == 0) continue;
                    idx = cfg_reg_t'(i);
                    sel = $urandom_range(0, 9);
                    case (idx)
                        REG_FILTER1_LEN:
                            val = (sel == 0) ? 40'hFFFF : (sel == 1) ? 40'd0
                                : 40'($urandom_range(1, 24));
                        REG_FILTER2_LEN:
                            val = (sel == 0) ? 40'($urandom_range(0, 511)) : (sel == 1) ? 40'd0
                                : (sel == 2) ? 40'd256 : 40'($urandom_range(1, 16));
                        REG_IMPULSE_TICKS:
                            val = (sel == 0) ? 40'hFF_FFFF_FFFF : (sel == 1) ? 40'd0
                                : (40'($urandom_range(0, 30)) << 16)
                                  | ((sel < 5) ? 40'd0 : 40'($urandom_range(0, 65535)));
                        REG_START_LEVEL:
                            val = (sel == 0) ? 40'($urandom) : (sel < 5) ? 40'd0
                                : (40'($urandom_range(0, 4)) << 16)
                                  | 40'($urandom_range(0, 65535));
                        REG_VELOCITY_SCALE:
                            val = (sel == 0) ? 40'hFFFF_FFFF
                                : 40'($urandom >> $urandom_range(0, 31));
                        REG_INITIAL_VELOCITY: begin
                            vel_tmp = $urandom >> $urandom_range(8, 31);
                            if ($urandom_range(0, 1) == 1) vel_tmp = -vel_tmp;
                            val = (sel == 0) ? 40'h8000_0000 : (sel == 1) ? 40'h7FFF_FFFF
                                : 40'(vel_tmp);
                        end
                        REG_STEP_TIME:
                            val = (sel == 0) ? 40'hFFFF_FFFF : (sel == 1) ? 40'd0
                                : (sel < 5) ? 40'd655 : 40'($urandom >> $urandom_range(8, 31));
                        REG_INVERSE_STEP_TIME:
                            val = (sel == 0) ? 40'hFFFF_FFFF : (sel == 1) ? 40'd0
                                : (sel < 5) ? 40'd6553600
                                : 40'($urandom >> $urandom_range(8, 31));
                        default: val = '0;
                    endcase
                    write_reg(idx, val);
                end
                first_rand = 1'b0;
            end
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                // noise: random restart and final flags
                n = $urandom_range(1, 8);
                repeat (n) plan_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                // a whole profile, or a continuation of the running one
                n = $urandom_range(2, 40);
                plan_tick(shape != 1, 1'b0);
                repeat (n - 2) plan_tick(1'b0, 1'b0);
                plan_tick(1'b0, 1'b1);
            end
        end

        // drain, then allow a little longer for any stray beat
        wait_idle();
        repeat (32) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_second_order_filter_motion_profile passed");
        end else begin
            $display("tb_second_order_filter_motion_profile failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/sofmp_pkg.sv
design/sofmp_ram.sv
design/sofmp_mul.sv
design/second_order_filter_motion_profile.sv
design/sofmp_checker.sv
bench/tb_second_order_filter_motion_profile.sv
